>>> hw/rtl/lcfc_pkg.sv
// ----------------------------------------------------------------------------
// lcfc_pkg
// Shared types, status codes and the crc-16/modbus byte update for the
// length-prefixed frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfc_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 258;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned STATUS_W = 3;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // frame layout: length byte, payload, two crc bytes
  localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 9'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_PENDING = 3'd0,
    ST_OK      = 3'd1,
    ST_SHORT   = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_BADCRC  = 3'd4
  } status_t;

  typedef struct packed {
    logic              end_of_message;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    status_t           frame_status;
    logic              frame_done;
    logic              is_payload;
    logic [BYTE_W-1:0] data_out;
  } res_item_t;

  // one byte folded into a reflected crc, eight shift steps
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcfc_pipe_reg.sv
// ----------------------------------------------------------------------------
// lcfc_pipe_reg
// One valid/ready register stage; takes a new transfer whenever it is empty
// or its content leaves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfc_pipe_reg #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s_valid,
  output logic                  s_ready,
  input  wire logic [WIDTH-1:0] s_data,
  output logic                  m_valid,
  input  wire logic             m_ready,
  output logic [WIDTH-1:0]      m_data
);

  logic             valid_r;
  logic             valid_nxt;
  logic [WIDTH-1:0] data_r;

  assign s_ready   = !valid_r || m_ready;
  assign valid_nxt = s_ready ? s_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= s_data;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

`default_nettype wire

>>> hw/rtl/lcfc_frame_eval.sv
// ----------------------------------------------------------------------------
// lcfc_frame_eval
// Frame state (byte count, declared length, running crc) and the per-byte
// result: payload mark and the verdict on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfc_frame_eval #(
  parameter int unsigned MAX_FRAME_BYTES = lcfc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire lcfc_pkg::in_item_t item,
  output lcfc_pkg::res_item_t    result
);

  localparam logic [lcfc_pkg::COUNT_W-1:0] MaxCount =
    lcfc_pkg::COUNT_W'(MAX_FRAME_BYTES);

  logic [lcfc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [lcfc_pkg::BYTE_W-1:0]  length_r, length_nxt;
  logic [lcfc_pkg::CRC_W-1:0]   crc_r, crc_nxt;

  logic                         taken;
  logic [lcfc_pkg::COUNT_W-1:0] total;
  logic [lcfc_pkg::BYTE_W-1:0]  length_now;
  logic [lcfc_pkg::CRC_W-1:0]   crc_now;
  logic [lcfc_pkg::COUNT_W-1:0] expected;
  lcfc_pkg::status_t            verdict;

  // bytes past the buffer size are echoed but neither counted nor folded
  assign taken      = count_r < MaxCount;
  assign total      = taken ? count_r + 1'b1 : count_r;
  assign length_now = (taken && count_r == '0) ? item.rx_byte : length_r;
  assign crc_now    = taken ? lcfc_pkg::crc_fold(crc_r, item.rx_byte) : crc_r;
  assign expected   = {1'b0, length_now} + lcfc_pkg::FRAME_OVERHEAD;

  always_comb begin
    if (total < lcfc_pkg::FRAME_OVERHEAD) begin
      verdict = lcfc_pkg::ST_SHORT;
    end else if (total != expected) begin
      verdict = lcfc_pkg::ST_LENGTH;
    end else if (crc_now != '0) begin
      verdict = lcfc_pkg::ST_BADCRC;
    end else begin
      verdict = lcfc_pkg::ST_OK;
    end
  end

  always_comb begin
    result.data_out     = item.rx_byte;
    result.is_payload   = taken && count_r != '0 &&
                          count_r <= {1'b0, length_r};
    result.frame_done   = item.end_of_message;
    result.frame_status = item.end_of_message ? verdict : lcfc_pkg::ST_PENDING;
  end

  always_comb begin
    if (item.end_of_message) begin
      count_nxt  = '0;
      length_nxt = '0;
      crc_nxt    = lcfc_pkg::CRC_INIT;
    end else begin
      count_nxt  = total;
      length_nxt = length_now;
      crc_nxt    = crc_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      length_r <= '0;
      crc_r    <= lcfc_pkg::CRC_INIT;
    end else if (advance) begin
      count_r  <= count_nxt;
      length_r <= length_nxt;
      crc_r    <= crc_nxt;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MaxCount)
    else $error("byte count beyond buffer size");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.end_of_message |=>
      count_r == '0 && length_r == '0 && crc_r == lcfc_pkg::CRC_INIT)
    else $error("frame state not cleared after last byte");

  a_length_byte_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> !result.is_payload)
    else $error("length byte marked as payload");

  // while a transfer moves on, a status other than pending comes only with the last byte
  a_status_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> (result.frame_status != lcfc_pkg::ST_PENDING) == result.frame_done)
    else $error("status and done disagree");

endmodule

`default_nettype wire

>>> hw/rtl/length_crc_frame_checker.sv
// ----------------------------------------------------------------------------
// length_crc_frame_checker
// Checks length-prefixed frames with a crc-16/modbus trailer, byte by byte.
// ----------------------------------------------------------------------------
// One byte per transfer, one result per byte, at a sustained rate of one byte
// per cycle while out_tready holds; each byte passes the input register, then
// the result register. The rate is set by the frame state loop: byte count,
// declared length and crc are updated once per byte, the crc by an
// eight-step bytewise fold. Each byte is echoed with a payload mark
// for positions 1 to the declared length. The byte with in_tlast ends the
// frame and its result carries out_tlast and the status (ok, too short, length
// mismatch, bad crc); the frame state then returns to reset. Bytes beyond
// MAX_FRAME_BYTES are echoed but not counted or checked.
`default_nettype none

module length_crc_frame_checker #(
  parameter int unsigned MAX_FRAME_BYTES = lcfc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_byte
  input  wire logic       in_tlast,   // end_of_message
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] data_out
  output logic            out_tlast,  // frame_done
  output logic [3:0]      out_tuser   // [0] is_payload, [3:1] frame_status
);

  lcfc_pkg::in_item_t  in_item;
  lcfc_pkg::in_item_t  held_item;
  lcfc_pkg::res_item_t result;
  lcfc_pkg::res_item_t out_item;
  logic                held_valid;
  logic                res_ready;

  assign in_item.rx_byte        = in_tdata;
  assign in_item.end_of_message = in_tlast;

  lcfc_pipe_reg #(
    .WIDTH($bits(lcfc_pkg::in_item_t))
  ) u_in_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .s_valid(in_tvalid),
    .s_ready(in_tready),
    .s_data (in_item),
    .m_valid(held_valid),
    .m_ready(res_ready),
    .m_data (held_item)
  );

  lcfc_frame_eval #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(held_valid && res_ready),
    .item   (held_item),
    .result (result)
  );

  lcfc_pipe_reg #(
    .WIDTH($bits(lcfc_pkg::res_item_t))
  ) u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .s_valid(held_valid),
    .s_ready(res_ready),
    .s_data (result),
    .m_valid(out_tvalid),
    .m_ready(out_tready),
    .m_data (out_item)
  );

  assign out_tdata = out_item.data_out;
  assign out_tlast = out_item.frame_done;
  assign out_tuser = {out_item.frame_status, out_item.is_payload};

endmodule

`default_nettype wire
